[rtl/rlphe_pkg.sv]
// Shared types and constants of the RLP item header encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package rlphe_pkg;

    // Header offsets and limits of the length prefix scheme.
    localparam logic [7:0] OFFSET_STRING = 8'd128;
    localparam logic [7:0] OFFSET_LIST   = 8'd192;
    localparam logic [7:0] BARE_LIMIT    = 8'h80;
    localparam logic [7:0] LONG_BASE     = 8'd55;
    localparam logic [31:0] SHORT_LIMIT  = 32'd56;

    // Width of the length byte counter: the length field holds at most four bytes.
    localparam int LEN_CNT_W = 3;

    // One input beat.
    typedef struct packed {
        logic        is_list;
        logic [31:0] payload_len;
        logic [7:0]  data_byte;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Work for the back end: an optional header byte, up to four length bytes
    // and an optional payload byte, emitted in that order.
    typedef struct packed {
        logic                 has_hdr;
        logic [7:0]           hdr_byte;
        logic                 hdr_last;
        logic [LEN_CNT_W-1:0] n_len;
        logic [31:0]          len_value;
        logic                 has_data;
        logic [7:0]           data_byte;
        logic                 data_last;
    } cmd_t;

    // Emission phase of the back end.
    typedef enum logic [1:0] {
        PH_HDR,
        PH_LEN,
        PH_DATA
    } phase_t;

endpackage

[rtl/rlphe_front.sv]
// Front end of the RLP item header encoder: accepts input beats, tracks the
// payload still due and turns each beat into one back-end command. Uses rlphe_pkg.
module rlphe_front #(
    parameter int LEN_BYTES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rlphe_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output rlphe_pkg::cmd_t   cmd_data
);

    localparam int LB_EFF = (LEN_BYTES < 4) ? LEN_BYTES : 4;
    localparam int LW     = 8 * LB_EFF;

    logic [LW-1:0] rem_reg;
    logic [LW-1:0] rem_next;
    logic [31:0]   len_sat;
    logic [31:0]   len_m1;
    logic [7:0]    offset;
    logic [2:0]    n_bytes;
    logic          bare;
    logic          accept;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    // Lengths beyond what the length field can carry saturate to its maximum.
    if (LW < 32) begin : g_sat
        always_comb begin
            if (s_data.payload_len[31:LW] != '0) begin
                len_sat = {{(32-LW){1'b0}}, {LW{1'b1}}};
            end else begin
                len_sat = s_data.payload_len;
            end
        end
    end else begin : g_nosat
        assign len_sat = s_data.payload_len;
    end

    assign len_m1 = len_sat - 32'd1;
    assign offset = s_data.is_list ? rlphe_pkg::OFFSET_LIST : rlphe_pkg::OFFSET_STRING;
    assign bare   = !s_data.is_list && (len_sat == 32'd1)
                    && (s_data.data_byte < rlphe_pkg::BARE_LIMIT);

    // Minimal big-endian byte count of the length.
    always_comb begin
        if (len_sat[31:24] != 8'd0) begin
            n_bytes = 3'd4;
        end else if (len_sat[23:16] != 8'd0) begin
            n_bytes = 3'd3;
        end else if (len_sat[15:8] != 8'd0) begin
            n_bytes = 3'd2;
        end else begin
            n_bytes = 3'd1;
        end
    end

    // Classify the beat: payload continuation, bare byte, short or long header.
    always_comb begin
        cmd_data           = '0;
        cmd_data.data_byte = s_data.data_byte;
        rem_next           = rem_reg;
        if (rem_reg != '0) begin
            cmd_data.has_data  = 1'b1;
            cmd_data.data_last = (rem_reg == {{(LW-1){1'b0}}, 1'b1});
            rem_next           = rem_reg - {{(LW-1){1'b0}}, 1'b1};
        end else if (bare) begin
            cmd_data.has_data  = 1'b1;
            cmd_data.data_last = 1'b1;
        end else begin
            cmd_data.has_hdr   = 1'b1;
            cmd_data.has_data  = (len_sat != 32'd0);
            cmd_data.data_last = (len_sat == 32'd1);
            cmd_data.len_value = len_sat;
            if (len_sat < rlphe_pkg::SHORT_LIMIT) begin
                cmd_data.hdr_byte = offset + len_sat[7:0];
                cmd_data.hdr_last = (len_sat == 32'd0);
            end else begin
                cmd_data.hdr_byte = offset + rlphe_pkg::LONG_BASE + {5'd0, n_bytes};
                cmd_data.n_len    = n_bytes;
            end
            if (len_sat != 32'd0) begin
                rem_next = len_m1[LW-1:0];
            end
        end
    end

    // Payload bytes still due in the current item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (accept) begin
            rem_reg <= rem_next;
        end
    end

endmodule

[rtl/rlphe_fifo.sv]
// Two-entry command queue between the front and back ends of the encoder.
// Uses rlphe_pkg for the command type.
module rlphe_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rlphe_pkg::cmd_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rlphe_pkg::cmd_t rd_data
);

    rlphe_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Entry storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/rlphe_back.sv]
// Back end of the encoder: takes commands from the queue and emits their
// header, length and payload bytes through a registered output. Uses rlphe_pkg.
module rlphe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  rlphe_pkg::cmd_t      cmd_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rlphe_pkg::out_item_t m_data
);

    rlphe_pkg::cmd_t               cmd_reg;
    logic                          busy_reg;
    rlphe_pkg::phase_t             phase_reg;
    rlphe_pkg::phase_t             phase_next;
    logic [rlphe_pkg::LEN_CNT_W-1:0] cnt_reg;
    logic [rlphe_pkg::LEN_CNT_W-1:0] cnt_next;
    logic                          m_valid_reg;
    rlphe_pkg::out_item_t          m_data_reg;
    logic [7:0]                    cur_byte;
    logic [7:0]                    len_byte;
    logic                          cur_last;
    logic                          final_step;
    logic                          step;
    logic                          load;

    assign step      = busy_reg && (!m_valid_reg || m_ready);
    assign load      = cmd_valid && (!busy_reg || (step && final_step));
    assign cmd_ready = !busy_reg || (step && final_step);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Length bytes go out most significant first.
    always_comb begin
        case (cnt_reg)
            3'd4:    len_byte = cmd_reg.len_value[31:24];
            3'd3:    len_byte = cmd_reg.len_value[23:16];
            3'd2:    len_byte = cmd_reg.len_value[15:8];
            default: len_byte = cmd_reg.len_value[7:0];
        endcase
    end

    // Byte, last flag and end of command for the current phase.
    always_comb begin
        case (phase_reg)
            rlphe_pkg::PH_HDR: begin
                cur_byte   = cmd_reg.hdr_byte;
                cur_last   = cmd_reg.hdr_last;
                final_step = (cmd_reg.n_len == '0) && !cmd_reg.has_data;
            end
            rlphe_pkg::PH_LEN: begin
                cur_byte   = len_byte;
                cur_last   = 1'b0;
                final_step = (cnt_reg == 3'd1) && !cmd_reg.has_data;
            end
            default: begin
                cur_byte   = cmd_reg.data_byte;
                cur_last   = cmd_reg.data_last;
                final_step = 1'b1;
            end
        endcase
    end

    // Next phase and length byte count.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (load) begin
            phase_next = cmd_data.has_hdr ? rlphe_pkg::PH_HDR : rlphe_pkg::PH_DATA;
            cnt_next   = cmd_data.n_len;
        end else if (step) begin
            case (phase_reg)
                rlphe_pkg::PH_HDR: begin
                    phase_next = (cmd_reg.n_len != '0) ? rlphe_pkg::PH_LEN
                                                       : rlphe_pkg::PH_DATA;
                end
                rlphe_pkg::PH_LEN: begin
                    cnt_next = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1) begin
                        phase_next = rlphe_pkg::PH_DATA;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Sequencer state and the held command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= rlphe_pkg::PH_HDR;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (load) begin
                busy_reg <= 1'b1;
            end else if (step && final_step) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= cmd_data;
        end
    end

    // Output register: holds a beat until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg.out_byte <= cur_byte;
            m_data_reg.out_last <= cur_last;
        end
    end

endmodule

[rtl/rlp_item_header_encoder_unit.sv]
// RLP item header encoder: each input beat carries one payload byte; the first beat of an
// item also gives its kind and length, and the block emits the length-prefix header ahead
// of that byte, marking the final byte of the item with out_last. Payload bytes flow at one
// per cycle while the sink is ready; an item start emits 1 to 6 output bytes (header
// byte, up to four length bytes, first payload byte) from the back-end byte sequencer.
// The input side accepts a beat per cycle while the two-entry command queue has room.
// Lengths wider than LEN_BYTES bytes saturate. Depends on rlphe_pkg and its submodules.
module rlp_item_header_encoder_unit #(
    parameter int LEN_BYTES = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rlphe_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rlphe_pkg::out_item_t m_data
);

    logic            fr_valid;
    logic            fr_ready;
    rlphe_pkg::cmd_t fr_cmd;
    logic            bk_valid;
    logic            bk_ready;
    rlphe_pkg::cmd_t bk_cmd;

    // Classification of input beats.
    rlphe_front #(
        .LEN_BYTES(LEN_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_valid(fr_valid),
        .cmd_ready(fr_ready),
        .cmd_data (fr_cmd)
    );

    // Decoupling queue.
    rlphe_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(fr_valid),
        .wr_ready(fr_ready),
        .wr_data (fr_cmd),
        .rd_valid(bk_valid),
        .rd_ready(bk_ready),
        .rd_data (bk_cmd)
    );

    // Byte sequencer and output register.
    rlphe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(bk_valid),
        .cmd_ready(bk_ready),
        .cmd_data (bk_cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
